// ----- hw/rtl/u2f_pkg.sv -----
// Package for the unsigned integer to binary64 converter.
// Holds format codes, width codes and shared constants; no dependencies.
package u2f_pkg;
   localparam int unsigned SigSingle = 24;
   localparam int unsigned SigDouble = 53;
   localparam logic [10:0] ExpBias = 11'd1023;

   typedef enum logic [2:0] {
      SW_1  = 3'd0,
      SW_4  = 3'd1,
      SW_8  = 3'd2,
      SW_16 = 3'd3,
      SW_32 = 3'd4,
      SW_64 = 3'd5
   } src_width_type;

   typedef enum logic [1:0] {
      TF_SINGLE = 2'd0,
      TF_DOUBLE = 2'd1
   } tgt_fmt_type;

   typedef struct packed {
      logic [63:0] x;
      logic        single;
      logic        warn;
   } u2f_op_type;
endpackage

// ----- hw/rtl/u2f_norm.sv -----
// Operand decode and normalization: masks to source width, finds the
// leading one and left-justifies. Depends on u2f_pkg.
module u2f_norm (
   input  logic [63:0]        value,
   input  logic [2:0]         source_width,
   input  logic [1:0]         target_format,
   output u2f_pkg::u2f_op_type op,
   output logic [63:0]        norm,
   output logic [5:0]         msb
);
   logic [63:0] x;
   logic [63:0] s;
   logic [5:0]  lz;

   always_comb begin
      case (source_width)
         u2f_pkg::SW_1:  x = {63'd0, value[0]};
         u2f_pkg::SW_4:  x = {60'd0, value[3:0]};
         u2f_pkg::SW_8:  x = {56'd0, value[7:0]};
         u2f_pkg::SW_16: x = {48'd0, value[15:0]};
         u2f_pkg::SW_32: x = {32'd0, value[31:0]};
         default:        x = value;
      endcase
   end

   // six-step binary leading-zero count and shift
   always_comb begin
      s  = x;
      lz = '0;
      if (s[63:32] == '0) begin s = s << 32; lz[5] = 1'b1; end
      if (s[63:48] == '0) begin s = s << 16; lz[4] = 1'b1; end
      if (s[63:56] == '0) begin s = s << 8;  lz[3] = 1'b1; end
      if (s[63:60] == '0) begin s = s << 4;  lz[2] = 1'b1; end
      if (s[63:62] == '0) begin s = s << 2;  lz[1] = 1'b1; end
      if (s[63] == 1'b0)  begin s = s << 1;  lz[0] = 1'b1; end
   end

   assign norm      = s;
   assign msb       = ~lz;
   assign op.x      = x;
   assign op.single = (target_format == u2f_pkg::TF_SINGLE);
   assign op.warn   = (target_format != u2f_pkg::TF_SINGLE) &&
                      (target_format != u2f_pkg::TF_DOUBLE);
endmodule

// ----- hw/rtl/u2f_round.sv -----
// Round-to-nearest-even of a left-justified operand and binary64 packing.
// Depends on u2f_pkg.
module u2f_round (
   input  u2f_pkg::u2f_op_type op,
   input  logic [63:0]        norm,
   input  logic [5:0]         msb,
   output logic [63:0]        result_bits
);
   logic [52:0] keep;
   logic        guard;
   logic        sticky;
   logic        inc;
   logic [53:0] sum;
   logic [10:0] expo;
   logic [51:0] frac;

   always_comb begin
      if (op.single) begin
         keep   = {norm[63:40], 29'd0};
         guard  = norm[39];
         sticky = |norm[38:0];
         inc    = guard & (sticky | norm[40]);
         sum    = {1'b0, keep} + {24'd0, inc, 29'd0};
      end else begin
         keep   = norm[63:11];
         guard  = norm[10];
         sticky = |norm[9:0];
         inc    = guard & (sticky | norm[11]);
         sum    = {1'b0, keep} + {53'd0, inc};
      end
      // carry out of rounding: significand is 1.000..., bump exponent
      expo = u2f_pkg::ExpBias + {5'd0, msb} + {10'd0, sum[53]};
      frac = sum[53] ? 52'd0 : sum[51:0];
      result_bits = (op.x == '0) ? 64'd0 : {1'b0, expo, frac};
   end
endmodule

// ----- hw/rtl/unsigned_int_to_float_convert.sv -----
// Unsigned integer to IEEE-754 binary64 converter, top level.
// Instantiates u2f_norm and u2f_round; uses u2f_pkg.
//
// One transaction in, one out. Each accepted item is captured in an
// input register, normalized and rounded in one combinational pass,
// and lands in the result register. A new transaction is taken every
// cycle; req_tready stays high while the result register is empty or
// being drained. Width codes 6/7 leave the value unmasked; target
// codes 2/3 convert as double and set the warning bit in rsp_tuser.
// Zero gives +0.0.
module unsigned_int_to_float_convert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [63:0] value, [66:64] source_width,
                                    // [68:67] target_format, rest zero
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [63:0] rsp_tdata,   // [63:0] result_bits
   output logic        rsp_tuser    // [0] type_warning
);
   logic        in_vld_ff, in_vld_in;
   logic [68:0] in_dat_ff;
   logic        out_vld_ff, out_vld_in;
   logic [63:0] out_dat_ff;
   logic        out_wrn_ff;

   u2f_pkg::u2f_op_type op;
   logic [63:0] norm;
   logic [5:0]  msb;
   logic [63:0] res;
   logic        adv;

   // stage 2 moves when result register is free or draining
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = !in_vld_ff || adv;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign out_vld_in = adv ? in_vld_ff : out_vld_ff;

   u2f_norm u_norm (
      .value        (in_dat_ff[63:0]),
      .source_width (in_dat_ff[66:64]),
      .target_format(in_dat_ff[68:67]),
      .op           (op),
      .norm         (norm),
      .msb          (msb)
   );

   u2f_round u_round (
      .op         (op),
      .norm       (norm),
      .msb        (msb),
      .result_bits(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_tready && req_tvalid) in_dat_ff <= req_tdata[68:0];
      if (adv && in_vld_ff) begin
         out_dat_ff <= res;
         out_wrn_ff <= op.warn;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_dat_ff;
   assign rsp_tuser  = out_wrn_ff;
endmodule

// ----- hw/rtl/u2f_checker.sv -----
// Port-level checker for unsigned_int_to_float_convert, with bind.
// Depends only on the top level's ports.
module u2f_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response dropped or changed under stall");
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[63])
      else $error("negative result");
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   // an empty result register fills only from a transaction accepted through the input register
   a_nofab: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without transaction");
endmodule

bind unsigned_int_to_float_convert u2f_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
   .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
